// ----- rtl/core/cmuxbfb_pkg.sv -----
// shared types, constants and crc helper for the cmux basic-mode frame builder
`timescale 1ns / 1ps

package cmuxbfb_pkg;

  localparam logic [7:0] FlagOctet   = 8'hF9;
  localparam logic [7:0] CrcInit     = 8'hFF;
  localparam logic [7:0] CrcPolyRefl = 8'hE0;

  localparam int unsigned CmdDepthDefault = 4;
  localparam int unsigned OutDepthDefault = 2;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_DATA,
    CMD_ERR
  } cmd_kind_e;

  // one classified input item, as handed from front to back
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] len_oct;
    logic [7:0] data;
    logic       closes;  // header of zero length, or last payload byte
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       protocol_error;
  } res_t;

  // one octet through the reflected crc-8
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CrcPolyRefl;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/cmuxbfb_fifo.sv -----
// small synchronous fifo used for the command queue and the result queue
`timescale 1ns / 1ps

module cmuxbfb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/core/cmuxbfb_front.sv -----
// front end: accepts items, tracks the open frame and classifies each beat
`timescale 1ns / 1ps

module cmuxbfb_front
  import cmuxbfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       opcode_i,
  input  logic [7:0] channel_address_i,
  input  logic [7:0] control_byte_i,
  input  logic [6:0] payload_length_i,
  input  logic       length_adjust_i,
  input  logic [7:0] data_byte_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o,
  input  logic       cmd_full_i
);

  // a frame is open exactly while payload bytes are still expected
  logic [6:0] remaining_q, remaining_d;
  logic [6:0] enc_len;
  logic       accept;

  assign full       = cmd_full_i;
  assign accept     = push & ~cmd_full_i;
  assign cmd_push_o = accept;
  assign enc_len    = (payload_length_i == '0) ? 7'd0
                    : payload_length_i - {6'd0, length_adjust_i};

  always_comb begin
    cmd_o         = '0;
    cmd_o.addr    = channel_address_i;
    cmd_o.ctrl    = control_byte_i;
    cmd_o.len_oct = {enc_len, 1'b1};
    cmd_o.data    = data_byte_i;
    remaining_d   = remaining_q;
    if (!opcode_i) begin
      cmd_o.kind   = CMD_HDR;
      cmd_o.closes = (payload_length_i == '0);
      remaining_d  = payload_length_i;
    end else if (remaining_q == '0) begin
      cmd_o.kind = CMD_ERR;
    end else begin
      cmd_o.kind   = CMD_DATA;
      cmd_o.closes = (remaining_q == 7'd1);
      remaining_d  = remaining_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
    end else if (accept) begin
      remaining_q <= remaining_d;
    end
  end

endmodule

// ----- rtl/core/cmuxbfb_back.sv -----
// back end: commands to frame bytes, one result beat per cycle unless stalled
`timescale 1ns / 1ps

module cmuxbfb_back
  import cmuxbfb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  output logic res_push_o,
  output res_t res_o,
  input  logic res_full_i
);

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_ADDR,
    ST_CTRL,
    ST_LEN,
    ST_CHECK,
    ST_CLOSE
  } state_e;

  state_e     state_q, state_d;
  cmd_t       cmd_q, cmd_d;
  logic [7:0] crc_q, crc_d;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    crc_d      = crc_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    if (!res_full_i) begin
      case (state_q)
        ST_FETCH: begin
          if (!cmd_empty_i) begin
            cmd_pop_o  = 1'b1;
            res_push_o = 1'b1;
            cmd_d      = cmd_i;
            case (cmd_i.kind)
              CMD_HDR: begin
                res_o.out_byte = FlagOctet;
                state_d        = ST_ADDR;
              end
              CMD_DATA: begin
                res_o.out_byte = cmd_i.data;
                state_d        = cmd_i.closes ? ST_CHECK : ST_FETCH;
              end
              default: begin
                res_o.protocol_error = 1'b1;
              end
            endcase
          end
        end
        ST_ADDR: begin
          res_push_o     = 1'b1;
          res_o.out_byte = cmd_q.addr;
          crc_d          = crc_byte(CrcInit, cmd_q.addr);
          state_d        = ST_CTRL;
        end
        ST_CTRL: begin
          res_push_o     = 1'b1;
          res_o.out_byte = cmd_q.ctrl;
          crc_d          = crc_byte(crc_q, cmd_q.ctrl);
          state_d        = ST_LEN;
        end
        ST_LEN: begin
          res_push_o     = 1'b1;
          res_o.out_byte = cmd_q.len_oct;
          // the check octet is kept already inverted for the rest of the frame
          crc_d          = ~crc_byte(crc_q, cmd_q.len_oct);
          state_d        = cmd_q.closes ? ST_CHECK : ST_FETCH;
        end
        ST_CHECK: begin
          res_push_o     = 1'b1;
          res_o.out_byte = crc_q;
          state_d        = ST_CLOSE;
        end
        ST_CLOSE: begin
          res_push_o      = 1'b1;
          res_o.out_byte  = FlagOctet;
          res_o.frame_end = 1'b1;
          state_d         = ST_FETCH;
        end
        default: begin
          state_d = ST_FETCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FETCH;
      cmd_q   <= '0;
      crc_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      crc_q   <= crc_d;
    end
  end

endmodule

// ----- rtl/core/cmux_basic_frame_builder_core.sv -----
// Basic-mode multiplexer frame builder, top level.
// Input channel: an item is taken on a clock edge with push high and full low.
// opcode_i low is a frame header (address, control, length, length adjust);
// opcode_i high is one payload byte on data_byte_i.
// Result channel: the oldest frame byte sits on out_byte_o, frame_end_o and
// protocol_error_o while empty is low; it is taken on an edge with pop high.
// A header gives flag, address, control and length bytes, plus check and
// closing flag when its length is zero. The last payload byte is followed by
// the check byte and the closing flag. A payload byte with no open frame gives
// one beat flagged as an error.
// The first result of an item passes through the command queue and then the result queue.
// The byte sequencer gives one result beat per cycle while commands wait and the result
// queue has room, so payload bytes then stream one per cycle.
// The command queue (CmdDepth entries) lets input keep flowing while the
// sequencer works through a header.
// Reset clears both queues and closes any frame. When pop stays low the result
// queue fills, then the command queue, and full rises; nothing is dropped.
`timescale 1ns / 1ps

module cmux_basic_frame_builder_core
  import cmuxbfb_pkg::*;
#(
  parameter int unsigned CmdDepth = CmdDepthDefault,
  parameter int unsigned OutDepth = OutDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       opcode_i,
  input  logic [7:0] channel_address_i,
  input  logic [7:0] control_byte_i,
  input  logic [6:0] payload_length_i,
  input  logic       length_adjust_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic       protocol_error_o
);

  cmd_t fe_cmd;
  cmd_t be_cmd;
  logic fe_cmd_push;
  logic cmdq_full;
  logic cmdq_empty;
  logic be_cmd_pop;
  res_t be_res;
  logic be_res_push;
  logic resq_full;
  res_t resq_head;

  cmuxbfb_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .opcode_i          (opcode_i),
    .channel_address_i (channel_address_i),
    .control_byte_i    (control_byte_i),
    .payload_length_i  (payload_length_i),
    .length_adjust_i   (length_adjust_i),
    .data_byte_i       (data_byte_i),
    .cmd_push_o        (fe_cmd_push),
    .cmd_o             (fe_cmd),
    .cmd_full_i        (cmdq_full)
  );

  cmuxbfb_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_cmd_push),
    .wdata_i (fe_cmd),
    .full_o  (cmdq_full),
    .pop_i   (be_cmd_pop),
    .rdata_o (be_cmd),
    .empty_o (cmdq_empty)
  );

  cmuxbfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (be_cmd),
    .cmd_empty_i (cmdq_empty),
    .cmd_pop_o   (be_cmd_pop),
    .res_push_o  (be_res_push),
    .res_o       (be_res),
    .res_full_i  (resq_full)
  );

  cmuxbfb_fifo #(
    .Width ($bits(res_t)),
    .Depth (OutDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (be_res_push),
    .wdata_i (be_res),
    .full_o  (resq_full),
    .pop_i   (pop),
    .rdata_o (resq_head),
    .empty_o (empty)
  );

  assign out_byte_o       = resq_head.out_byte;
  assign frame_end_o      = resq_head.frame_end;
  assign protocol_error_o = resq_head.protocol_error;

endmodule

// ----- tb/cmux_basic_frame_builder_core_tb.sv -----
// self-checking testbench for the cmux basic-mode frame builder core
`timescale 1ns / 1ps

module cmux_basic_frame_builder_core_tb;
  import cmuxbfb_pkg::*;

  localparam logic OpHeader = 1'b0;
  localparam logic OpPayload = 1'b1;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomItems = 130;
  localparam int unsigned MaxReports = 40;

  // tracks frame state and holds the byte stream the block owes us
  class frame_scoreboard;
    res_t frame_bytes_due[$];
    bit hdr_open;
    logic [6:0] bytes_left;
    logic [7:0] frame_check;
    int unsigned mismatches;

    function new();
      hdr_open = 1'b0;
      bytes_left = '0;
      frame_check = '0;
      mismatches = 0;
    endfunction

    // reflected crc-8, one input bit at a time
    function logic [7:0] crc8_refl(logic [7:0] crc, logic [7:0] octet);
      logic [7:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        if (c[0] ^ octet[i]) begin
          c = (c >> 1) ^ CrcPolyRefl;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    endfunction

    function void queue_beat(logic [7:0] octet, logic fend, logic perr);
      res_t r;
      r.out_byte = octet;
      r.frame_end = fend;
      r.protocol_error = perr;
      frame_bytes_due.push_back(r);
    endfunction

    function void note_item(logic op, logic [7:0] addr, logic [7:0] ctrl,
                            logic [6:0] len, logic adj, logic [7:0] data);
      logic [6:0] enc;
      logic [7:0] len_oct;
      logic [7:0] chk;
      if (op == OpHeader) begin
        // adjust only applies to a nonzero length
        enc = (len == 7'd0) ? 7'd0 : len - 7'(adj);
        len_oct = {enc, 1'b1};
        chk = ~crc8_refl(crc8_refl(crc8_refl(CrcInit, addr), ctrl), len_oct);
        queue_beat(FlagOctet, 1'b0, 1'b0);
        queue_beat(addr, 1'b0, 1'b0);
        queue_beat(ctrl, 1'b0, 1'b0);
        queue_beat(len_oct, 1'b0, 1'b0);
        if (len == 7'd0) begin
          queue_beat(chk, 1'b0, 1'b0);
          queue_beat(FlagOctet, 1'b1, 1'b0);
          hdr_open = 1'b0;
          bytes_left = '0;
          frame_check = '0;
        end else begin
          hdr_open = 1'b1;
          bytes_left = len;
          frame_check = chk;
        end
      end else if (!hdr_open || bytes_left == 7'd0) begin
        queue_beat(8'h00, 1'b0, 1'b1);
      end else begin
        queue_beat(data, 1'b0, 1'b0);
        bytes_left = bytes_left - 7'd1;
        if (bytes_left == 7'd0) begin
          queue_beat(frame_check, 1'b0, 1'b0);
          queue_beat(FlagOctet, 1'b1, 1'b0);
          hdr_open = 1'b0;
          frame_check = '0;
        end
      end
    endfunction

    function void flag_field(string field, logic [7:0] want, logic [7:0] got);
      if (mismatches < MaxReports) begin
        $display("%0t: %s expected %02h, got %02h", $time, field, want, got);
      end
      mismatches++;
    endfunction

    function void check_beat(logic [7:0] octet, logic fend, logic perr);
      res_t due;
      if (frame_bytes_due.size() == 0) begin
        if (mismatches < MaxReports) begin
          $display("%0t: unexpected beat, expected none, got byte %02h end %0b err %0b",
                   $time, octet, fend, perr);
        end
        mismatches++;
        return;
      end
      due = frame_bytes_due.pop_front();
      if (octet !== due.out_byte) flag_field("out_byte", due.out_byte, octet);
      if (fend !== due.frame_end) flag_field("frame_end", 8'(due.frame_end), 8'(fend));
      if (perr !== due.protocol_error) begin
        flag_field("protocol_error", 8'(due.protocol_error), 8'(perr));
      end
    endfunction

    function int unsigned pending();
      return frame_bytes_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic opcode_i = OpHeader;
  logic [7:0] channel_address_i = '0;
  logic [7:0] control_byte_i = '0;
  logic [6:0] payload_length_i = '0;
  logic length_adjust_i = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_byte_o;
  logic frame_end_o;
  logic protocol_error_o;

  frame_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit tx_burst = 1'b0;

  cmux_basic_frame_builder_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .opcode_i         (opcode_i),
    .channel_address_i(channel_address_i),
    .control_byte_i   (control_byte_i),
    .payload_length_i (payload_length_i),
    .length_adjust_i  (length_adjust_i),
    .data_byte_i      (data_byte_i),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .frame_end_o      (frame_end_o),
    .protocol_error_o (protocol_error_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // both handshakes sampled on the edge, before anything is updated
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_item(opcode_i, channel_address_i, control_byte_i, payload_length_i,
                     length_adjust_i, data_byte_i);
      end
      if (pop && !empty) sb.check_beat(out_byte_o, frame_end_o, protocol_error_o);
    end
  end

  task automatic send_item(input logic op, input logic [7:0] addr, input logic [7:0] ctrl,
                           input logic [6:0] len, input logic adj, input logic [7:0] data);
    int unsigned gap;
    opcode_i <= op;
    channel_address_i <= addr;
    control_byte_i <= ctrl;
    payload_length_i <= len;
    length_adjust_i <= adj;
    data_byte_i <= data;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    items_sent++;
    gap = tx_burst ? 0 : idle_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_header(input logic [7:0] addr, input logic [7:0] ctrl,
                             input logic [6:0] len, input logic adj);
    send_item(OpHeader, addr, ctrl, len, adj, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] data);
    send_item(OpPayload, 8'($urandom), 8'($urandom), 7'($urandom), 1'($urandom), data);
  endtask

  // one edge first so the last accepted beat is already in the scoreboard
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned run;
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      pop <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = idle_len();
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned n;
    int unsigned random_start;
    int unsigned big_frames;
    bit paused;
    logic [6:0] len;
    big_frames = 0;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // payload with no frame open
    send_payload(8'h00);
    // zero length, adjust ignored
    send_header(8'h00, 8'h00, 7'd0, 1'b0);
    send_header(8'hFF, 8'hFF, 7'd0, 1'b1);
    send_header(8'h03, 8'hEF, 7'd1, 1'b0);
    send_payload(8'hA5);
    send_header(8'h81, 8'h3F, 7'd1, 1'b1);
    send_payload(8'h5A);
    // stray byte after the frame closed
    send_payload(8'hFF);
    // longest frame, abandoned by the next header
    send_header(8'hFF, 8'hFF, 7'd127, 1'b1);
    send_payload(8'h11);
    send_payload(8'h22);
    send_header(8'h07, 8'h53, 7'd2, 1'b0);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_header(8'h80, 8'h01, 7'd3, 1'b1);
    send_payload(8'h55);
    send_payload(8'hAA);
    send_payload(8'h0F);
    send_header(8'h7F, 8'h80, 7'd127, 1'b0);
    send_header(8'hC3, 8'h3C, 7'd0, 1'b0);
    wait_drained();

    random_start = items_sent;
    while (items_sent - random_start < RandomItems) begin
      if (!paused && items_sent - random_start >= RandomItems / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_payload(8'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          len = 7'd0;
        end else if (r < 94 || big_frames >= 2) begin
          len = 7'($urandom_range(1, 8));
        end else begin
          len = 7'($urandom_range(9, 127));
          big_frames++;
        end
        send_header(8'($urandom), 8'($urandom), len, 1'($urandom));
        n = 32'(len);
        r = $urandom_range(0, 99);
        // cut the frame short now and then, or overrun it by one byte
        if (r < 10 && len != 7'd0) n = $urandom_range(0, 32'(len) - 1);
        // the item budget also ends a long frame early
        for (int i = 0; i < n && items_sent - random_start < RandomItems; i++) begin
          send_payload(8'($urandom));
        end
        if (r >= 92) send_payload(8'($urandom));
      end
    end
    tx_burst = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
